FILE: rtl/core/lps_pkg.sv
// Shared types and constants for the four-connected line pixel stepper.
package lps_pkg;

  // Bytes per video row; each byte packs two pixels.
  localparam int unsigned RowBytes = 80;

  // Width of the unclipped address sum before it is cut to the port width.
  localparam int unsigned AddrSumW = 16;

  // Command codes.
  localparam logic CmdStart = 1'b0;
  localparam logic CmdStep  = 1'b1;

  // Nibble masks for the byte being rewritten.
  localparam logic [7:0] KeepHigh = 8'hF0;
  localparam logic [7:0] KeepLow  = 8'h0F;

  // Input item.
  typedef struct packed {
    logic       command;
    logic [7:0] x_start;
    logic [6:0] y_start;
    logic [7:0] x_end;
    logic [6:0] y_end;
    logic [3:0] pen_color;
  } line_cmd_t;

  // Result item: one pixel write.
  typedef struct packed {
    logic [13:0] byte_address;
    logic [7:0]  keep_mask;
    logic [7:0]  write_bits;
    logic        last_pixel;
  } pixel_write_t;

endpackage

FILE: rtl/core/line_pixel_stepper.sv
// Four-connected line rasterizer that emits nibble-packed pixel writes.
//
// Usage: the input channel (in_valid_i, in_stall_o, in_data_i) takes commands.
// A start command loads both endpoints and the pen color and gives no result.
// Each step command on an active line gives one pixel write on the output
// channel (out_valid_o, out_stall_i, out_data_o) and moves one pixel along the
// line; last_pixel marks the final write, after which the line goes idle. A
// step while idle is consumed and gives nothing. Equal endpoints load an idle
// line. The end point itself is never written.
//
// Timing: a pixel write is registered and appears in the cycle after its step
// is transferred. Throughput: one command per cycle while the input is not
// stalled; the line state and the output register are both updated in the
// cycle of the transfer, so steps may arrive back to back.
// Stall: the output register holds its write while out_stall_i is high; a new
// command is taken in that cycle only if the register is empty or drains.
// Reset: line state clears to idle and the output register empties.
module line_pixel_stepper (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  lps_pkg::line_cmd_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output lps_pkg::pixel_write_t out_data_o
);
  import lps_pkg::*;

  // Line state.
  logic       active_q, active_d;
  logic [7:0] col_q, col_d;
  logic [6:0] row_q, row_d;
  logic [7:0] goal_col_q, goal_col_d;
  logic [6:0] goal_row_q, goal_row_d;
  logic       col_bwd_q, col_bwd_d;
  logic       row_bwd_q, row_bwd_d;
  logic [7:0] dist_col_q, dist_col_d;
  logic [6:0] dist_row_q, dist_row_d;
  logic signed [8:0] err_q, err_d;
  logic [3:0] color_q, color_d;

  // Output register.
  logic         out_valid_q, out_valid_d;
  pixel_write_t out_data_q, out_data_d;

  logic              in_xfer;
  logic              emit;
  logic              odd_col;
  logic [AddrSumW-1:0] addr_sum;
  logic [7:0]        step_col;
  logic [6:0]        step_row;
  logic signed [8:0] step_err;
  logic              s_col_bwd, s_row_bwd;
  logic [7:0]        s_dist_col;
  logic [6:0]        s_dist_row;

  // Take a command when the output register is empty or drains this cycle.
  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_xfer    = in_valid_i & ~in_stall_o;
  assign emit       = in_xfer & (in_data_i.command == CmdStep) & active_q;

  // Address and nibble placement of the current pixel.
  assign odd_col  = col_q[0];
  assign addr_sum = AddrSumW'(1) + AddrSumW'(2) * (AddrSumW'(RowBytes) * AddrSumW'(row_q)
                    + AddrSumW'(col_q[7:1]));

  // One four-connected move.
  always_comb begin
    step_col = col_q;
    step_row = row_q;
    if (err_q[8]) begin
      step_row = row_bwd_q ? row_q - 7'd1 : row_q + 7'd1;
      step_err = err_q + $signed({1'b0, dist_col_q});
    end else begin
      step_col = col_bwd_q ? col_q - 8'd1 : col_q + 8'd1;
      step_err = err_q - $signed({2'b0, dist_row_q});
    end
  end

  // Directions and distances for a start.
  assign s_col_bwd  = in_data_i.x_start > in_data_i.x_end;
  assign s_row_bwd  = in_data_i.y_start > in_data_i.y_end;
  assign s_dist_col = s_col_bwd ? in_data_i.x_start - in_data_i.x_end
                                : in_data_i.x_end - in_data_i.x_start;
  assign s_dist_row = s_row_bwd ? in_data_i.y_start - in_data_i.y_end
                                : in_data_i.y_end - in_data_i.y_start;

  // Next line state.
  always_comb begin
    active_d   = active_q;
    col_d      = col_q;
    row_d      = row_q;
    goal_col_d = goal_col_q;
    goal_row_d = goal_row_q;
    col_bwd_d  = col_bwd_q;
    row_bwd_d  = row_bwd_q;
    dist_col_d = dist_col_q;
    dist_row_d = dist_row_q;
    err_d      = err_q;
    color_d    = color_q;
    if (in_xfer && in_data_i.command == CmdStart) begin
      col_d      = in_data_i.x_start;
      row_d      = in_data_i.y_start;
      goal_col_d = in_data_i.x_end;
      goal_row_d = in_data_i.y_end;
      col_bwd_d  = s_col_bwd;
      row_bwd_d  = s_row_bwd;
      dist_col_d = s_dist_col;
      dist_row_d = s_dist_row;
      err_d      = (s_dist_col == 8'd0) ? -9'sd1 : 9'sd0;
      color_d    = in_data_i.pen_color;
      active_d   = !(in_data_i.x_start == in_data_i.x_end &&
                     in_data_i.y_start == in_data_i.y_end);
    end else if (emit) begin
      col_d    = step_col;
      row_d    = step_row;
      err_d    = step_err;
      active_d = !(step_col == goal_col_q && step_row == goal_row_q);
    end
  end

  // Next output register.
  always_comb begin
    out_data_d = out_data_q;
    if (emit) begin
      out_valid_d             = 1'b1;
      out_data_d.byte_address = addr_sum[13:0];
      out_data_d.keep_mask    = odd_col ? KeepLow : KeepHigh;
      out_data_d.write_bits   = odd_col ? {color_q, 4'h0} : {4'h0, color_q};
      out_data_d.last_pixel   = (step_col == goal_col_q && step_row == goal_row_q);
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Hold line state and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      col_q       <= '0;
      row_q       <= '0;
      goal_col_q  <= '0;
      goal_row_q  <= '0;
      col_bwd_q   <= 1'b0;
      row_bwd_q   <= 1'b0;
      dist_col_q  <= '0;
      dist_row_q  <= '0;
      err_q       <= '0;
      color_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      active_q    <= active_d;
      col_q       <= col_d;
      row_q       <= row_d;
      goal_col_q  <= goal_col_d;
      goal_row_q  <= goal_row_d;
      col_bwd_q   <= col_bwd_d;
      row_bwd_q   <= row_bwd_d;
      dist_col_q  <= dist_col_d;
      dist_row_q  <= dist_row_d;
      err_q       <= err_d;
      color_q     <= color_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload needs no reset.
  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

FILE: rtl/core/lps_checker.sv
// Port-level checker for the line pixel stepper, bound to the top level.
module lps_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input lps_pkg::line_cmd_t    in_data_i,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input lps_pkg::pixel_write_t out_data_o
);
  import lps_pkg::*;

  // Hold a stalled write.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled pixel write dropped or changed");

  // Stall the input only when the output register is full and blocked.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a blocked output");

  // Without a step transfer, a drained output register stays empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o || !out_stall_i) &&
    !(in_valid_i && !in_stall_o && in_data_i.command == CmdStep) |=> !out_valid_o)
    else $error("pixel write without a step");

  // Write exactly one nibble, never into the kept half.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.keep_mask == KeepHigh || out_data_o.keep_mask == KeepLow) &&
                    ((out_data_o.write_bits & out_data_o.keep_mask) == 8'h00))
    else $error("bad nibble mask or write bits");

endmodule

bind line_pixel_stepper lps_checker u_lps_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

FILE: tb/sv/lps_pixel_audit.sv
// Predicts the pixel writes of the line stepper and compares each write it returns.
module lps_pixel_audit
  import lps_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  input  logic         in_stall_i,
  input  line_cmd_t    in_data_i,
  input  logic         out_valid_i,
  input  logic         out_stall_i,
  input  pixel_write_t out_data_i,
  output int           mismatch_count_o,
  output int           pending_o,
  output int           writes_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Line state as the stepper should hold it.
  logic              line_on;
  logic [7:0]        at_col, goal_col, span_col;
  logic [6:0]        at_row, goal_row, span_row;
  logic              back_col, back_row;
  logic signed [8:0] slope_err;
  logic [3:0]        ink;

  // Writes predicted but not yet seen on the output channel.
  pixel_write_t expected_writes[$];

  // Apply one command to the line state and queue the write it causes.
  task automatic trace_command(input line_cmd_t cmd);
    pixel_write_t px;
    logic [31:0]  offset;
    int           err;
    if (cmd.command == CmdStart) begin
      at_col    = cmd.x_start;
      at_row    = cmd.y_start;
      goal_col  = cmd.x_end;
      goal_row  = cmd.y_end;
      back_col  = cmd.x_start > cmd.x_end;
      back_row  = cmd.y_start > cmd.y_end;
      span_col  = back_col ? cmd.x_start - cmd.x_end : cmd.x_end - cmd.x_start;
      span_row  = back_row ? cmd.y_start - cmd.y_end : cmd.y_end - cmd.y_start;
      // a vertical line starts one below zero so it moves in y first
      slope_err = (span_col == '0) ? -9'sd1 : 9'sd0;
      ink       = cmd.pen_color;
      line_on   = (cmd.x_start != cmd.x_end) || (cmd.y_start != cmd.y_end);
    end else if (line_on) begin
      // write the current point: two pixels per byte, no clipping
      offset          = 32'd1 + 32'd2 * (RowBytes * at_row + (at_col >> 1));
      px.byte_address = offset[13:0];
      px.keep_mask    = at_col[0] ? KeepLow : KeepHigh;
      px.write_bits   = at_col[0] ? {ink, 4'h0} : {4'h0, ink};
      // advance one four-connected move
      if (slope_err < 0) begin
        at_row = back_row ? at_row - 7'd1 : at_row + 7'd1;
        err    = int'(slope_err) + int'(span_col);
      end else begin
        at_col = back_col ? at_col - 8'd1 : at_col + 8'd1;
        err    = int'(slope_err) - int'(span_row);
      end
      slope_err      = err[8:0];
      px.last_pixel  = (at_col == goal_col) && (at_row == goal_row);
      if (px.last_pixel) line_on = 1'b0;
      expected_writes.push_back(px);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    pixel_write_t want;
    if (!rst_ni) begin
      line_on   = 1'b0;
      at_col    = '0;
      at_row    = '0;
      goal_col  = '0;
      goal_row  = '0;
      back_col  = 1'b0;
      back_row  = 1'b0;
      span_col  = '0;
      span_row  = '0;
      slope_err = '0;
      ink       = '0;
      expected_writes.delete();
      mismatch_count_o = 0;
      writes_o         = 0;
    end else begin
      // check the write leaving this cycle before predicting new ones
      if (out_valid_i && !out_stall_i) begin
        writes_o++;
        if (expected_writes.size() == 0) begin
          if (mismatch_count_o < 10)
            $display("%0t: unexpected pixel write addr %h keep %h bits %h last %b",
                     $time, out_data_i.byte_address, out_data_i.keep_mask,
                     out_data_i.write_bits, out_data_i.last_pixel);
          mismatch_count_o++;
        end else begin
          want = expected_writes.pop_front();
          if (want.byte_address !== out_data_i.byte_address ||
              want.keep_mask    !== out_data_i.keep_mask    ||
              want.write_bits   !== out_data_i.write_bits   ||
              want.last_pixel   !== out_data_i.last_pixel) begin
            if (mismatch_count_o < 10)
              $display("%0t: write %0d expected addr %h keep %h bits %h last %b, got %h %h %h %b",
                       $time, writes_o, want.byte_address, want.keep_mask,
                       want.write_bits, want.last_pixel, out_data_i.byte_address,
                       out_data_i.keep_mask, out_data_i.write_bits,
                       out_data_i.last_pixel);
            mismatch_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) trace_command(in_data_i);
    end
    pending_o = expected_writes.size();
  end

endmodule

FILE: tb/sv/line_pixel_stepper_test.sv
// Drives line commands into the pixel stepper, throttles both channels and gives the verdict.
module line_pixel_stepper_test
  import lps_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IdleLimit   = 500;
  localparam int RandomItems = 800;

  logic         clk_i       = 1'b0;
  logic         rst_ni      = 1'b0;
  logic         in_valid_i  = 1'b0;
  logic         in_stall_o;
  line_cmd_t    in_data_i   = '0;
  logic         out_valid_o;
  logic         out_stall_i = 1'b0;
  pixel_write_t out_data_o;

  int mismatches;
  int pending;
  int writes;
  int quiet_cycles  = 0;
  int commands_sent = 0;
  int starts_sent   = 0;
  int send_run      = 0;
  bit send_quiet    = 1'b0;
  int take_run      = 0;
  bit take_quiet    = 1'b0;

  line_pixel_stepper u_top (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .in_data_i,
    .out_valid_o,
    .out_stall_i,
    .out_data_o
  );

  lps_pixel_audit u_audit (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_i       (in_stall_o),
    .in_data_i,
    .out_valid_i      (out_valid_o),
    .out_stall_i,
    .out_data_i       (out_data_o),
    .mismatch_count_o (mismatches),
    .pending_o        (pending),
    .writes_o         (writes)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Draw a wait, mixing stretches of random waits with stretches of no idling.
  function automatic int pick_wait(inout int run_left, inout bit quiet);
    if (run_left == 0) begin
      run_left = $urandom_range(8, 40);
      quiet    = ($urandom_range(0, 3) == 0);
    end
    run_left--;
    return quiet ? 0 : $urandom_range(0, 14);
  endfunction

  // Fill every field, the command bit included, from two random words.
  function automatic line_cmd_t random_fields();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[$bits(line_cmd_t)-1:0];
  endfunction

  function automatic line_cmd_t make_start(int xs, int ys, int xe, int ye, logic [3:0] color);
    line_cmd_t cmd;
    cmd.command   = CmdStart;
    cmd.x_start   = xs[7:0];
    cmd.y_start   = ys[6:0];
    cmd.x_end     = xe[7:0];
    cmd.y_end     = ye[6:0];
    cmd.pen_color = color;
    return cmd;
  endfunction

  // Offer one command after a random gap and hold it until the transfer.
  task automatic push_command(input line_cmd_t cmd);
    int gap;
    bit taken;
    gap = pick_wait(send_run, send_quiet);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= cmd;
    do begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end while (!taken);
    commands_sent++;
    if (cmd.command == CmdStart) starts_sent++;
  endtask

  task automatic push_step();
    line_cmd_t cmd;
    cmd         = random_fields();
    cmd.command = CmdStep;
    push_command(cmd);
  endtask

  task automatic draw_line(input line_cmd_t start, input int steps);
    push_command(start);
    repeat (steps) push_step();
  endtask

  // Drop the input and hold off until every predicted write has drained.
  task automatic settle_writes();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
  endtask

  // Output side: raise the stall for a random wait before taking each write.
  initial begin : drain_writes
    int hold;
    bit seen;
    forever begin
      hold = pick_wait(take_run, take_quiet);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do begin
        @(negedge clk_i);
        seen = out_valid_o;
        @(posedge clk_i);
      end while (!seen);
    end
  end

  // Abort when no transfer happens for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles == IdleLimit) begin
        $display("FAILURE");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    line_cmd_t cmd;
    int        counted;
    int        shape;
    int        xs, ys, xe, ye;
    int        span;
    int        steps;
    bit        paused;
    counted = 0;
    paused  = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: idle step, equal endpoints, axis lines, field maxima, abandoned line.
    push_step();
    draw_line(make_start(0, 0, 0, 0, 4'h3), 1);
    draw_line(make_start(0, 0, 3, 0, 4'hF), 3);
    draw_line(make_start(159, 99, 159, 97, 4'hA), 2);
    draw_line(make_start(255, 127, 254, 126, 4'h5), 2);
    draw_line(make_start(10, 10, 20, 15, 4'h9), 1);
    draw_line(make_start(1, 2, 0, 3, 4'h0), 2);
    push_step();
    settle_writes();

    // Random: mostly whole lines, some cut short or overrun, plus noise.
    while (counted < RandomItems) begin
      if ($urandom_range(0, 99) < 82) begin
        shape = $urandom_range(0, 99);
        if (shape < 87) begin
          xs = $urandom_range(0, 159);
          ys = $urandom_range(0, 99);
          xe = $urandom_range(xs < 8 ? 0 : xs - 8, xs + 8);
          ye = $urandom_range(ys < 8 ? 0 : ys - 8, ys + 8);
        end else if (shape < 97) begin
          xs = $urandom_range(0, 159);
          ys = $urandom_range(0, 99);
          xe = $urandom_range(0, 159);
          ye = $urandom_range(0, 99);
        end else begin
          xs = $urandom_range(0, 255);
          ys = $urandom_range(0, 127);
          xe = $urandom_range(0, 255);
          ye = $urandom_range(0, 127);
        end
        span  = (xe > xs ? xe - xs : xs - xe) + (ye > ys ? ye - ys : ys - ye);
        steps = ($urandom_range(0, 9) == 0) ? $urandom_range(0, span) : span;
        draw_line(make_start(xs, ys, xe, ye, 4'($urandom_range(0, 15))), steps);
        counted += steps + 1;
        // add extra steps now and then; after a whole line those are ignored
        if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 3)) push_step();
      end else begin
        repeat ($urandom_range(1, 3)) begin
          cmd = random_fields();
          push_command(cmd);
          counted++;
        end
      end
      if (!paused && counted >= RandomItems / 2) begin
        settle_writes();
        paused = 1'b1;
      end
    end

    settle_writes();
    repeat (8) @(posedge clk_i);

    $display("Sent %0d commands (%0d line starts) and checked %0d pixel writes.",
             commands_sent, starts_sent, writes);
    $display("Lines ranged from single moves to full field spans, with idle and abandoned steps.");
    if (mismatches == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
